[rtl/elsq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elsq_pkg
// Shared constants and types of the edge least-squares gradient term core.
// ----------------------------------------------------------------------------
package elsq_pkg;

  localparam int unsigned WORD_BITS_DEF = 48;
  localparam int unsigned FRAC_BITS_DEF = 32;

  // load enables of the two register stages of one pipelined multiplier
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

endpackage

`default_nettype wire

[rtl/elsq_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elsq_if
// Valid/ready channels of the edge gradient term core: edge beats in,
// gradient term beats out.
// ----------------------------------------------------------------------------
interface elsq_in_if #(
  parameter int unsigned WORD_BITS = elsq_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] delta_x;
  logic signed [WORD_BITS-1:0] delta_y;
  logic signed [WORD_BITS-1:0] delta_z;
  logic                        endpoint;
  logic signed [WORD_BITS-1:0] wt_inv_r11;
  logic signed [WORD_BITS-1:0] wt_r12;
  logic signed [WORD_BITS-1:0] wt_r13;
  logic signed [WORD_BITS-1:0] wt_inv_r22;
  logic signed [WORD_BITS-1:0] wt_r23;
  logic signed [WORD_BITS-1:0] wt_inv_r33;
  logic signed [WORD_BITS-1:0] wt_cross;

  modport source (
    output valid, delta_x, delta_y, delta_z, endpoint, wt_inv_r11, wt_r12, wt_r13,
           wt_inv_r22, wt_r23, wt_inv_r33, wt_cross,
    input  ready
  );
  modport sink (
    input  valid, delta_x, delta_y, delta_z, endpoint, wt_inv_r11, wt_r12, wt_r13,
           wt_inv_r22, wt_r23, wt_inv_r33, wt_cross,
    output ready
  );
endinterface

interface elsq_out_if #(
  parameter int unsigned WORD_BITS = elsq_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] term_x;
  logic signed [WORD_BITS-1:0] term_y;
  logic signed [WORD_BITS-1:0] term_z;
  logic                        saturated;

  modport source (
    output valid, term_x, term_y, term_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, term_x, term_y, term_z, saturated,
    output ready
  );
endinterface

`default_nettype wire

[rtl/elsq_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elsq_mul
// Two-stage saturating fixed-point multiplier: half-width partial products,
// then sum, arithmetic shift by the fraction width and clamp.
// ----------------------------------------------------------------------------
module elsq_mul #(
  parameter int unsigned WORD_BITS = elsq_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = elsq_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire elsq_pkg::mul_en_t       en_i,
  input  wire logic signed [WORD_BITS-1:0] a_i,
  input  wire logic signed [WORD_BITS-1:0] b_i,
  output logic signed [WORD_BITS-1:0]  p_o,
  output logic                         sat_o
);
  import elsq_pkg::*;

  localparam int unsigned LO_BITS = WORD_BITS / 2;
  localparam int unsigned HI_BITS = WORD_BITS - LO_BITS;
  localparam int unsigned MX_BITS = LO_BITS + HI_BITS + 1;
  localparam int unsigned PW      = 2 * WORD_BITS;
  localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic        [LO_BITS-1:0]   a_lo, b_lo;
  logic signed [HI_BITS-1:0]   a_hi, b_hi;
  logic        [2*LO_BITS-1:0] ll_d, ll_q;
  logic signed [MX_BITS-1:0]   lh_d, lh_q, hl_d, hl_q;
  logic signed [2*HI_BITS-1:0] hh_d, hh_q;

  logic signed [PW-1:0]        hh_x, mid_x, ll_x, prod, shf;
  logic [WORD_BITS:0]          top_bits;
  logic signed [WORD_BITS-1:0] p_d;
  logic                        sat_d;

  // low halves unsigned, high halves carry the sign
  assign a_lo = a_i[LO_BITS-1:0];
  assign b_lo = b_i[LO_BITS-1:0];
  assign a_hi = a_i[WORD_BITS-1:LO_BITS];
  assign b_hi = b_i[WORD_BITS-1:LO_BITS];

  assign ll_d = (2*LO_BITS)'(a_lo) * (2*LO_BITS)'(b_lo);
  assign lh_d = MX_BITS'(signed'({1'b0, a_lo})) * MX_BITS'(b_hi);
  assign hl_d = MX_BITS'(a_hi) * MX_BITS'(signed'({1'b0, b_lo}));
  assign hh_d = (2*HI_BITS)'(a_hi) * (2*HI_BITS)'(b_hi);

  always_ff @(posedge clk_i) begin
    if (en_i.pp) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
  end

  always_comb begin
    hh_x     = PW'(hh_q) <<< (2 * LO_BITS);
    mid_x    = (PW'(lh_q) + PW'(hl_q)) <<< LO_BITS;
    ll_x     = signed'(PW'(ll_q));
    prod     = hh_x + mid_x + ll_x;
    shf      = prod >>> FRAC_BITS;
    top_bits = shf[PW-1:WORD_BITS-1];
    if ((&top_bits) || !(|top_bits)) begin
      p_d   = shf[WORD_BITS-1:0];
      sat_d = 1'b0;
    end else begin
      p_d   = shf[PW-1] ? SMIN : SMAX;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      p_o   <= p_d;
      sat_o <= sat_d;
    end
  end

endmodule

`default_nettype wire

[rtl/edge_lsq_gradient_terms_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// throughput: one edge per cycle unless a stalled output backs up to the input;
//   three chained multiply levels, each a two-stage multiplier, set the depth
// each stage holds its own valid bit, so a stalled output only backs up
//   the stages that are full
// reset clears the valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
// edge_lsq_gradient_terms_core
// Weighted least-squares gradient terms of one mesh edge endpoint, signed
// fixed point with saturation at every step.
// ----------------------------------------------------------------------------
module edge_lsq_gradient_terms_core #(
  parameter int unsigned WORD_BITS = elsq_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = elsq_pkg::FRAC_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  elsq_in_if.sink    edge_in_i,
  elsq_out_if.source term_out_o
);
  import elsq_pkg::*;

  localparam int unsigned ST_NEG  = 0;
  localparam int unsigned ST_M1PP = 1;
  localparam int unsigned ST_M1   = 2;
  localparam int unsigned ST_C0   = 3;
  localparam int unsigned ST_M2PP = 4;
  localparam int unsigned ST_M2   = 5;
  localparam int unsigned ST_C1   = 6;
  localparam int unsigned ST_M3PP = 7;
  localparam int unsigned ST_M3   = 8;
  localparam int unsigned ST_OUT  = 9;
  localparam int unsigned NUM_ST  = 10;

  localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef logic signed [WORD_BITS-1:0] word_t;

  // msb of the result is the clamp flag
  function automatic logic [WORD_BITS:0] sat_sum(input word_t a, input word_t b,
                                                 input logic sub);
    logic signed [WORD_BITS:0] s;
    logic [WORD_BITS:0]        r;
    if (sub) begin
      s = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
    end else begin
      s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
    end
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r = {1'b1, (s[WORD_BITS] ? SMIN : SMAX)};
    end else begin
      r = {1'b0, s[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- handshake
  logic [NUM_ST-1:0] v_q, v_d, en;

  always_comb begin
    en[ST_OUT] = !v_q[ST_OUT] || term_out_o.ready;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[NUM_ST-2:0], edge_in_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_ST; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  assign edge_in_i.ready = en[ST_NEG];

  // ------------------------------------------------------------ negate stage
  logic [WORD_BITS:0] nx_r, ny_r, nz_r;
  word_t dx_s1_q, dy_s1_q, dz_s1_q;
  word_t w0_s1_q, w1_s1_q, w2_s1_q, w3_s1_q, w4_s1_q, w5_s1_q, w6_s1_q;
  logic  sat_s1_q;

  always_comb begin
    if (edge_in_i.endpoint) begin
      nx_r = sat_sum('0, edge_in_i.delta_x, 1'b1);
      ny_r = sat_sum('0, edge_in_i.delta_y, 1'b1);
      nz_r = sat_sum('0, edge_in_i.delta_z, 1'b1);
    end else begin
      nx_r = {1'b0, edge_in_i.delta_x};
      ny_r = {1'b0, edge_in_i.delta_y};
      nz_r = {1'b0, edge_in_i.delta_z};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_NEG]) begin
      dx_s1_q  <= nx_r[WORD_BITS-1:0];
      dy_s1_q  <= ny_r[WORD_BITS-1:0];
      dz_s1_q  <= nz_r[WORD_BITS-1:0];
      sat_s1_q <= nx_r[WORD_BITS] | ny_r[WORD_BITS] | nz_r[WORD_BITS];
      w0_s1_q  <= edge_in_i.wt_inv_r11;
      w1_s1_q  <= edge_in_i.wt_r12;
      w2_s1_q  <= edge_in_i.wt_r13;
      w3_s1_q  <= edge_in_i.wt_inv_r22;
      w4_s1_q  <= edge_in_i.wt_r23;
      w5_s1_q  <= edge_in_i.wt_inv_r33;
      w6_s1_q  <= edge_in_i.wt_cross;
    end
  end

  // ------------------------------------------------- first multiply level
  mul_en_t m1_en, m2_en, m3_en;
  assign m1_en = '{pp: en[ST_M1PP], sum: en[ST_M1]};
  assign m2_en = '{pp: en[ST_M2PP], sum: en[ST_M2]};
  assign m3_en = '{pp: en[ST_M3PP], sum: en[ST_M3]};

  word_t p1, p2, p0, q, r;
  logic  p1_sat, p2_sat, p0_sat, q_sat, r_sat;

  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_p1 (
    .clk_i(clk_i), .en_i(m1_en), .a_i(dx_s1_q), .b_i(w1_s1_q), .p_o(p1), .sat_o(p1_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_p2 (
    .clk_i(clk_i), .en_i(m1_en), .a_i(dx_s1_q), .b_i(w2_s1_q), .p_o(p2), .sat_o(p2_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_p0 (
    .clk_i(clk_i), .en_i(m1_en), .a_i(dx_s1_q), .b_i(w0_s1_q), .p_o(p0), .sat_o(p0_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_q (
    .clk_i(clk_i), .en_i(m1_en), .a_i(w3_s1_q), .b_i(w1_s1_q), .p_o(q), .sat_o(q_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_r (
    .clk_i(clk_i), .en_i(m1_en), .a_i(w4_s1_q), .b_i(w5_s1_q), .p_o(r), .sat_o(r_sat)
  );

  word_t dy_s2_q, dz_s2_q, w3_s2_q, w4_s2_q, w5_s2_q, w6_s2_q;
  word_t dy_s3_q, dz_s3_q, w3_s3_q, w4_s3_q, w5_s3_q, w6_s3_q;
  logic  sat_s2_q, sat_s3_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_M1PP]) begin
      dy_s2_q  <= dy_s1_q;
      dz_s2_q  <= dz_s1_q;
      w3_s2_q  <= w3_s1_q;
      w4_s2_q  <= w4_s1_q;
      w5_s2_q  <= w5_s1_q;
      w6_s2_q  <= w6_s1_q;
      sat_s2_q <= sat_s1_q;
    end
    if (en[ST_M1]) begin
      dy_s3_q  <= dy_s2_q;
      dz_s3_q  <= dz_s2_q;
      w3_s3_q  <= w3_s2_q;
      w4_s3_q  <= w4_s2_q;
      w5_s3_q  <= w5_s2_q;
      w6_s3_q  <= w6_s2_q;
      sat_s3_q <= sat_s2_q;
    end
  end

  // ---------------------------------------------------------------- c0 stage
  logic [WORD_BITS:0] c0_r, c1a_r;
  word_t c0_s4_q, c1a_s4_q, p0_s4_q, q_s4_q, r_s4_q;
  word_t w3_s4_q, w4_s4_q, w5_s4_q, w6_s4_q;
  logic  sat_s4_q;

  assign c0_r  = sat_sum(dy_s3_q, p1, 1'b1);
  assign c1a_r = sat_sum(dz_s3_q, p2, 1'b1);

  always_ff @(posedge clk_i) begin
    if (en[ST_C0]) begin
      c0_s4_q  <= c0_r[WORD_BITS-1:0];
      c1a_s4_q <= c1a_r[WORD_BITS-1:0];
      p0_s4_q  <= p0;
      q_s4_q   <= q;
      r_s4_q   <= r;
      w3_s4_q  <= w3_s3_q;
      w4_s4_q  <= w4_s3_q;
      w5_s4_q  <= w5_s3_q;
      w6_s4_q  <= w6_s3_q;
      sat_s4_q <= sat_s3_q | p1_sat | p2_sat | p0_sat | q_sat | r_sat
                  | c0_r[WORD_BITS] | c1a_r[WORD_BITS];
    end
  end

  // ------------------------------------------------ second multiply level
  word_t s, tx1, ty0;
  logic  s_sat, tx1_sat, ty0_sat;

  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_s (
    .clk_i(clk_i), .en_i(m2_en), .a_i(w4_s4_q), .b_i(c0_s4_q), .p_o(s), .sat_o(s_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_tx1 (
    .clk_i(clk_i), .en_i(m2_en), .a_i(q_s4_q), .b_i(c0_s4_q), .p_o(tx1), .sat_o(tx1_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_ty0 (
    .clk_i(clk_i), .en_i(m2_en), .a_i(w3_s4_q), .b_i(c0_s4_q), .p_o(ty0), .sat_o(ty0_sat)
  );

  word_t c1a_s5_q, p0_s5_q, r_s5_q, w5_s5_q, w6_s5_q;
  word_t c1a_s6_q, p0_s6_q, r_s6_q, w5_s6_q, w6_s6_q;
  logic  sat_s5_q, sat_s6_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_M2PP]) begin
      c1a_s5_q <= c1a_s4_q;
      p0_s5_q  <= p0_s4_q;
      r_s5_q   <= r_s4_q;
      w5_s5_q  <= w5_s4_q;
      w6_s5_q  <= w6_s4_q;
      sat_s5_q <= sat_s4_q;
    end
    if (en[ST_M2]) begin
      c1a_s6_q <= c1a_s5_q;
      p0_s6_q  <= p0_s5_q;
      r_s6_q   <= r_s5_q;
      w5_s6_q  <= w5_s5_q;
      w6_s6_q  <= w6_s5_q;
      sat_s6_q <= sat_s5_q;
    end
  end

  // ---------------------------------------------------------------- c1 stage
  logic [WORD_BITS:0] c1_r, txa_r;
  word_t c1_s7_q, txa_s7_q, ty0_s7_q, r_s7_q, w5_s7_q, w6_s7_q;
  logic  sat_s7_q;

  assign c1_r  = sat_sum(c1a_s6_q, s, 1'b1);
  assign txa_r = sat_sum(p0_s6_q, tx1, 1'b1);

  always_ff @(posedge clk_i) begin
    if (en[ST_C1]) begin
      c1_s7_q  <= c1_r[WORD_BITS-1:0];
      txa_s7_q <= txa_r[WORD_BITS-1:0];
      ty0_s7_q <= ty0;
      r_s7_q   <= r_s6_q;
      w5_s7_q  <= w5_s6_q;
      w6_s7_q  <= w6_s6_q;
      sat_s7_q <= sat_s6_q | s_sat | tx1_sat | ty0_sat | c1_r[WORD_BITS] | txa_r[WORD_BITS];
    end
  end

  // ------------------------------------------------- third multiply level
  word_t tx2, ty1, tz;
  logic  tx2_sat, ty1_sat, tz_sat;

  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_tx2 (
    .clk_i(clk_i), .en_i(m3_en), .a_i(w6_s7_q), .b_i(c1_s7_q), .p_o(tx2), .sat_o(tx2_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_ty1 (
    .clk_i(clk_i), .en_i(m3_en), .a_i(r_s7_q), .b_i(c1_s7_q), .p_o(ty1), .sat_o(ty1_sat)
  );
  elsq_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul_tz (
    .clk_i(clk_i), .en_i(m3_en), .a_i(w5_s7_q), .b_i(c1_s7_q), .p_o(tz), .sat_o(tz_sat)
  );

  word_t txa_s8_q, ty0_s8_q, txa_s9_q, ty0_s9_q;
  logic  sat_s8_q, sat_s9_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_M3PP]) begin
      txa_s8_q <= txa_s7_q;
      ty0_s8_q <= ty0_s7_q;
      sat_s8_q <= sat_s7_q;
    end
    if (en[ST_M3]) begin
      txa_s9_q <= txa_s8_q;
      ty0_s9_q <= ty0_s8_q;
      sat_s9_q <= sat_s8_q;
    end
  end

  // ------------------------------------------------------------ output stage
  logic [WORD_BITS:0] tx_r, ty_r;
  word_t tx_q, ty_q, tz_q;
  logic  sat_q;

  assign tx_r = sat_sum(txa_s9_q, tx2, 1'b0);
  assign ty_r = sat_sum(ty0_s9_q, ty1, 1'b1);

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      tx_q  <= tx_r[WORD_BITS-1:0];
      ty_q  <= ty_r[WORD_BITS-1:0];
      tz_q  <= tz;
      sat_q <= sat_s9_q | tx2_sat | ty1_sat | tz_sat | tx_r[WORD_BITS] | ty_r[WORD_BITS];
    end
  end

  assign term_out_o.valid     = v_q[ST_OUT];
  assign term_out_o.term_x    = tx_q;
  assign term_out_o.term_y    = ty_q;
  assign term_out_o.term_z    = tz_q;
  assign term_out_o.saturated = sat_q;

  // -------------------------------------------------------------- assertions
  // a full pipe with a stalled output takes no new beat
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !term_out_o.ready) |-> !edge_in_i.ready)
    else $error("input ready while pipeline full and output stalled");

  // an accepted beat occupies the first stage on the next edge
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_in_i.valid && edge_in_i.ready) |=> v_q[ST_NEG])
    else $error("accepted edge beat lost at entry");

  // an item leaving the last multiply level reaches the output register
  a_tail_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_M3] && en[ST_OUT]) |=> v_q[ST_OUT])
    else $error("item lost between last multiply level and output");

  // a stalled stage keeps its item
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_C1] && !en[ST_C1]) |=> v_q[ST_C1])
    else $error("stalled stage dropped its item");

endmodule

`default_nettype wire

[tb/tb_edge_lsq_gradient_terms_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_lsq_gradient_terms_core
// Streams edge beats through the gradient term core and checks every term
// beat against a bit-exact fixed-point predictor kept in this bench. The run
// starts with corner cases and then sends random edges. Both channels idle at
// random, and there is one long output stall and two full drains.
// ----------------------------------------------------------------------------
module tb_edge_lsq_gradient_terms_core;

  localparam int WB         = elsq_pkg::WORD_BITS_DEF;
  localparam int FB         = elsq_pkg::FRAC_BITS_DEF;
  localparam int LATENCY    = 10;
  localparam int RAND_EDGES = 1528;
  localparam int STALL_AT   = 600;
  localparam int STALL_LEN  = 400;
  localparam int LIMIT      = 600000;

  typedef logic signed [WB-1:0] word_t;
  typedef logic signed [127:0]  acc_t;

  localparam acc_t  WORD_MAX = acc_t'({(WB-1){1'b1}});
  localparam acc_t  WORD_MIN = ~WORD_MAX;
  localparam word_t W_MAX    = {1'b0, {(WB-1){1'b1}}};
  localparam word_t W_MIN    = {1'b1, {(WB-1){1'b0}}};
  localparam word_t ONE      = word_t'(1) << FB;

  typedef struct packed {
    logic  drain;
    word_t delta_x;
    word_t delta_y;
    word_t delta_z;
    logic  endpoint;
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    word_t w4;
    word_t w5;
    word_t w6;
  } edge_beat_t;

  typedef struct packed {
    word_t term_x;
    word_t term_y;
    word_t term_z;
    logic  saturated;
  } terms_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  elsq_in_if  #(.WORD_BITS(WB)) edge_ch ();
  elsq_out_if #(.WORD_BITS(WB)) term_ch ();

  edge_lsq_gradient_terms_core #(
    .WORD_BITS(WB),
    .FRAC_BITS(FB)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .edge_in_i (edge_ch),
    .term_out_o(term_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  edge_beat_t  edge_backlog[$];
  terms_beat_t pending_terms[$];
  edge_beat_t  cur_edge;
  terms_beat_t want;
  bit          clip_seen;
  int          accepted_edges = 0;
  int          sent_ep1 = 0;
  int          checked_beats = 0;
  int          sat_beats = 0;
  int          fail_count = 0;
  int          cycles = 0;
  int          src_gap;
  int          snk_gap;
  int          stall_left;
  bit          stall_done;
  bit          src_calm = 1'b0;
  bit          snk_calm = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic word_t clip(input acc_t v);
    if (v > WORD_MAX) begin
      clip_seen = 1'b1;
      return WORD_MAX[WB-1:0];
    end
    if (v < WORD_MIN) begin
      clip_seen = 1'b1;
      return WORD_MIN[WB-1:0];
    end
    return v[WB-1:0];
  endfunction

  function automatic word_t q_add(input word_t a, input word_t b);
    acc_t wa, wb;
    wa = a;
    wb = b;
    return clip(wa + wb);
  endfunction

  function automatic word_t q_sub(input word_t a, input word_t b);
    acc_t wa, wb;
    wa = a;
    wb = b;
    return clip(wa - wb);
  endfunction

  function automatic word_t q_neg(input word_t a);
    acc_t wa;
    wa = a;
    return clip(-wa);
  endfunction

  // exact product, floor shift back to the fraction width
  function automatic word_t q_mul(input word_t a, input word_t b);
    acc_t wa, wb, p;
    wa = a;
    wb = b;
    p = (wa * wb) >>> FB;
    return clip(p);
  endfunction

  function automatic terms_beat_t gradient_terms_of(input edge_beat_t e);
    terms_beat_t t;
    word_t dx, dy, dz, c0, c1, tx, ty, tz;
    clip_seen = 1'b0;
    dx = e.delta_x;
    dy = e.delta_y;
    dz = e.delta_z;
    if (e.endpoint) begin
      dx = q_neg(dx);
      dy = q_neg(dy);
      dz = q_neg(dz);
    end
    c0 = q_sub(dy, q_mul(dx, e.w1));
    c1 = q_sub(dz, q_mul(dx, e.w2));
    c1 = q_sub(c1, q_mul(e.w4, c0));
    tx = q_mul(q_mul(e.w3, e.w1), c0);
    tx = q_sub(q_mul(dx, e.w0), tx);
    tx = q_add(tx, q_mul(e.w6, c1));
    ty = q_mul(q_mul(e.w4, e.w5), c1);
    ty = q_sub(q_mul(e.w3, c0), ty);
    tz = q_mul(e.w5, c1);
    t.term_x = tx;
    t.term_y = ty;
    t.term_z = tz;
    t.saturated = clip_seen;
    return t;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic edge_beat_t make_edge(input word_t dx, input word_t dy, input word_t dz,
                                           input logic ep, input word_t w0, input word_t w1,
                                           input word_t w2, input word_t w3, input word_t w4,
                                           input word_t w5, input word_t w6);
    edge_beat_t e;
    e.drain = 1'b0;
    e.delta_x = dx;
    e.delta_y = dy;
    e.delta_z = dz;
    e.endpoint = ep;
    e.w0 = w0;
    e.w1 = w1;
    e.w2 = w2;
    e.w3 = w3;
    e.w4 = w4;
    e.w5 = w5;
    e.w6 = w6;
    return e;
  endfunction

  // mostly mesh-like magnitudes, some full range and corner values
  function automatic word_t rand_word();
    logic [63:0] r;
    word_t v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = word_t'($signed(r[35:0]));
      5, 6:          v = word_t'($signed(r[43:0]));
      7:             v = r[WB-1:0];
      8: begin
        case ($urandom_range(0, 6))
          0:       v = W_MAX;
          1:       v = W_MIN;
          2:       v = '0;
          3:       v = 1;
          4:       v = -1;
          5:       v = ONE;
          default: v = -ONE;
        endcase
      end
      default:       v = ($urandom_range(0, 1) ? ONE : -ONE) + word_t'($signed(r[15:0]));
    endcase
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (edge_ch.valid && edge_ch.ready) begin
        pending_terms.push_back(gradient_terms_of(cur_edge));
        accepted_edges <= accepted_edges + 1;
        if (cur_edge.endpoint) sent_ep1 = sent_ep1 + 1;
      end
      if (!edge_ch.valid || edge_ch.ready) begin
        if (src_gap != 0) begin
          edge_ch.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (edge_backlog.size() != 0 &&
                     !(edge_backlog[0].drain && pending_terms.size() != 0)) begin
          cur_edge = edge_backlog.pop_front();
          edge_ch.delta_x    <= cur_edge.delta_x;
          edge_ch.delta_y    <= cur_edge.delta_y;
          edge_ch.delta_z    <= cur_edge.delta_z;
          edge_ch.endpoint   <= cur_edge.endpoint;
          edge_ch.wt_inv_r11 <= cur_edge.w0;
          edge_ch.wt_r12     <= cur_edge.w1;
          edge_ch.wt_r13     <= cur_edge.w2;
          edge_ch.wt_inv_r22 <= cur_edge.w3;
          edge_ch.wt_r23     <= cur_edge.w4;
          edge_ch.wt_inv_r33 <= cur_edge.w5;
          edge_ch.wt_cross   <= cur_edge.w6;
          edge_ch.valid      <= 1'b1;
          src_gap <= src_calm ? 0 : idle_len();
        end else begin
          edge_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_ch.ready <= 1'b0;
      snk_gap <= 0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left != 0) begin
      term_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && accepted_edges >= STALL_AT) begin
      // long hold-off while the driver keeps offering, backs up the pipe
      stall_done <= 1'b1;
      stall_left <= STALL_LEN;
      term_ch.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      term_ch.ready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else begin
      term_ch.ready <= 1'b1;
      snk_gap <= snk_calm ? 0 : idle_len();
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && term_ch.valid && term_ch.ready) begin
      if (pending_terms.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("unexpected term beat: x=%h y=%h z=%h sat=%b",
                   term_ch.term_x, term_ch.term_y, term_ch.term_z, term_ch.saturated);
      end else begin
        want = pending_terms.pop_front();
        checked_beats = checked_beats + 1;
        if (want.saturated) sat_beats = sat_beats + 1;
        if (term_ch.term_x !== want.term_x || term_ch.term_y !== want.term_y ||
            term_ch.term_z !== want.term_z || term_ch.saturated !== want.saturated) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("beat %0d mismatch: exp x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                     checked_beats, want.term_x, want.term_y, want.term_z, want.saturated,
                     term_ch.term_x, term_ch.term_y, term_ch.term_z, term_ch.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 200 == 0) begin
      src_calm <= ($urandom_range(0, 3) == 0);
      snk_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               pending_terms.size());
      $display("[edge_lsq_gradient_terms_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    edge_beat_t e;
    edge_ch.valid = 1'b0;
    edge_ch.delta_x = '0;
    edge_ch.delta_y = '0;
    edge_ch.delta_z = '0;
    edge_ch.endpoint = 1'b0;
    edge_ch.wt_inv_r11 = '0;
    edge_ch.wt_r12 = '0;
    edge_ch.wt_r13 = '0;
    edge_ch.wt_inv_r22 = '0;
    edge_ch.wt_r23 = '0;
    edge_ch.wt_inv_r33 = '0;
    edge_ch.wt_cross = '0;
    term_ch.ready = 1'b0;

    edge_backlog.push_back(make_edge(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    edge_backlog.push_back(make_edge(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    edge_backlog.push_back(make_edge(ONE, 2 * ONE, 3 * ONE, 0,
                                     ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    edge_backlog.push_back(make_edge(ONE, 2 * ONE, 3 * ONE, 1,
                                     ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    // negating the most negative delta clamps
    edge_backlog.push_back(make_edge(W_MIN, W_MIN, W_MIN, 1,
                                     ONE, 0, 0, ONE, 0, ONE, 0));
    edge_backlog.push_back(make_edge(W_MAX, W_MAX, W_MAX, 1,
                                     ONE, 0, 0, ONE, 0, ONE, 0));
    edge_backlog.push_back(make_edge(W_MAX, W_MAX, W_MAX, 0,
                                     W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
    edge_backlog.push_back(make_edge(W_MIN, W_MIN, W_MIN, 0,
                                     W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
    edge_backlog.push_back(make_edge(W_MIN, W_MIN, W_MIN, 1,
                                     W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
    edge_backlog.push_back(make_edge(W_MAX, W_MAX, W_MAX, 0,
                                     W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
    // lsb products: floor rounding toward minus infinity
    edge_backlog.push_back(make_edge(-1, -1, -1, 0, 1, 1, 1, 1, 1, 1, 1));
    edge_backlog.push_back(make_edge(1, 1, 1, 1, -1, -1, -1, -1, -1, -1, -1));
    edge_backlog.push_back(make_edge(-(ONE >>> 1), ONE >>> 2, -(ONE >>> 3), 0,
                                     ONE, -ONE, ONE >>> 1, 2 * ONE, -(ONE >>> 1), ONE, -ONE));
    // product overflow: 256.0 * 256.0
    edge_backlog.push_back(make_edge(word_t'(1) << 40, 0, 0, 0,
                                     0, word_t'(1) << 40, 0, 0, 0, 0, 0));
    edge_backlog.push_back(make_edge({(WB/2){2'b10}}, {(WB/2){2'b01}}, {(WB/2){2'b10}}, 1,
                                     {(WB/2){2'b01}}, {(WB/2){2'b10}}, {(WB/2){2'b01}},
                                     {(WB/2){2'b10}}, {(WB/2){2'b01}}, {(WB/2){2'b10}},
                                     {(WB/2){2'b01}}));
    // difference overflow in c0
    edge_backlog.push_back(make_edge(ONE, W_MAX, 0, 0, 0, -ONE, 0, 0, 0, 0, 0));
    edge_backlog.push_back(make_edge(5 * ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    edge_backlog.push_back(make_edge(0, 0, 7 * ONE, 1, 0, 0, 0, 0, 0, 3 * ONE, -2 * ONE));
    edge_backlog.push_back(make_edge(0, 3 * ONE, 0, 0, 0, 0, 0, 4 * ONE, ONE, ONE, 0));

    for (int i = 0; i < RAND_EDGES; i++) begin
      e = make_edge(rand_word(), rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                    rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word());
      // sender waits for an empty pipe before these
      if (i == 0 || i == 880) e.drain = 1'b1;
      edge_backlog.push_back(e);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (edge_backlog.size() != 0 || edge_ch.valid) @(posedge clk_i);
    while (pending_terms.size() != 0) @(posedge clk_i);
    repeat (3 * LATENCY) @(posedge clk_i);

    if (pending_terms.size() != 0) begin
      fail_count = fail_count + 1;
      $display("%0d term beats never arrived", pending_terms.size());
    end
    $display("%0d edges sent (%0d seen from the second node), %0d term beats checked",
             accepted_edges, sent_ep1, checked_beats);
    $display("%0d results clamped, %0d failures, %0d cycles", sat_beats, fail_count, cycles);
    if (fail_count == 0) begin
      $display("[edge_lsq_gradient_terms_core] OK");
    end else begin
      $display("[edge_lsq_gradient_terms_core] ERROR");
    end
    $finish;
  end

endmodule
